// ===== design/fpfa_pkg.sv =====
package fpfa_pkg;

  // Table geometry.
  localparam int NUM_PARTS = 16;
  localparam int IDX_W     = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int SCAN_W    = $clog2(NUM_PARTS + 1);

  // Field widths of the words on the ports.
  localparam int CNT_W  = 5;
  localparam int OP_W   = 1;
  localparam int POL_W  = 2;
  localparam int SLOT_W = 4;
  localparam int SIZE_W = 16;
  localparam int PID_W  = 8;
  localparam int STAT_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

  // Placement policies.
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_LOADED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ALLOC  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFIT  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
    logic commit;
  } fpfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_req;
    logic scan_done;
    logic out_free;
  } fpfa_status_t;

endpackage

// ===== design/fpfa_item_if.sv =====
interface fpfa_item_if;
  import fpfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [POL_W-1:0]  policy;
  logic [SLOT_W-1:0] slot_index;
  logic [SIZE_W-1:0] size_value;
  logic [PID_W-1:0]  process_id;

  modport source (
    output valid, operation, policy, slot_index, size_value, process_id,
    input  ready
  );

  modport sink (
    input  valid, operation, policy, slot_index, size_value, process_id,
    output ready
  );

endinterface

// ===== design/fpfa_result_if.sv =====
interface fpfa_result_if;
  import fpfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] partition_index;
  logic [PID_W-1:0]  echo_id;

  modport source (
    output valid, status, partition_index, echo_id,
    input  ready
  );

  modport sink (
    input  valid, status, partition_index, echo_id,
    output ready
  );

endinterface

// ===== design/fpfa_ram.sv =====
module fpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fpfa_datapath.sv =====
module fpfa_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [fpfa_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic [fpfa_pkg::OP_W-1:0]   operation_i,
  input  logic [fpfa_pkg::POL_W-1:0]  policy_i,
  input  logic [fpfa_pkg::SLOT_W-1:0] slot_index_i,
  input  logic [fpfa_pkg::SIZE_W-1:0] size_value_i,
  input  logic [fpfa_pkg::PID_W-1:0]  process_id_i,
  input  fpfa_pkg::fpfa_cmd_t         cmd_i,
  output fpfa_pkg::fpfa_status_t      status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fpfa_pkg::STAT_W-1:0] out_status_o,
  output logic [fpfa_pkg::SLOT_W-1:0] out_index_o,
  output logic [fpfa_pkg::PID_W-1:0]  out_echo_o
);
  import fpfa_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [SCAN_W-1:0] limit;

  logic [OP_W-1:0]   op_q;
  logic [POL_W-1:0]  policy_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SIZE_W-1:0] need_q;
  logic [PID_W-1:0]  pid_q;

  logic [SCAN_W-1:0] issue_q;
  logic              cmp_v_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              found_q;
  logic [IDX_W-1:0]  pick_q;
  logic [SIZE_W-1:0] pick_size_q;
  logic [NUM_PARTS-1:0] taken_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [SLOT_W-1:0] out_index_q;
  logic [PID_W-1:0]  out_echo_q;

  logic              issuing;
  logic              hit;
  logic              slot_ok;
  logic              load_wr;
  logic [SIZE_W-1:0] rdata;

  // Partition count register, clamped to the table depth for the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (int'(count_q) > NUM_PARTS) begin
      limit = SCAN_W'(NUM_PARTS);
    end else begin
      limit = SCAN_W'(count_q);
    end
  end

  // Latch the accepted word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= operation_i;
      policy_q <= policy_i;
      slot_q   <= slot_index_i;
      need_q   <= size_value_i;
      pid_q    <= process_id_i;
    end
  end

  // Size table: written by loads at commit, read once per scan step.
  assign slot_ok = int'(slot_q) < NUM_PARTS;
  assign load_wr = cmd_i.commit && (op_q == OP_LOAD) && slot_ok;
  assign issuing = cmd_i.step && (issue_q < limit);

  fpfa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (NUM_PARTS)
  ) u_sizes (
    .clk_i   (clk_i),
    .we_i    (load_wr),
    .waddr_i (IDX_W'(slot_q)),
    .wdata_i (need_q),
    .re_i    (issuing),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // The entry read last cycle is compared against the request and the current pick.
  assign hit = cmp_v_q && !taken_q[cmp_idx_q] && (rdata >= need_q) &&
               (!found_q ||
                ((policy_q == POL_BEST)  && (rdata < pick_size_q)) ||
                ((policy_q == POL_WORST) && (rdata > pick_size_q)));

  // Scan control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= '0;
      cmp_v_q <= 1'b0;
      found_q <= 1'b0;
    end else if (cmd_i.accept) begin
      issue_q <= '0;
      cmp_v_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      cmp_v_q <= issuing;
      if (issuing) begin
        issue_q <= issue_q + SCAN_W'(1);
      end
      if (hit) begin
        found_q <= 1'b1;
      end
    end
  end

  // Scan payload registers.
  always_ff @(posedge clk_i) begin
    if (issuing) begin
      cmp_idx_q <= issue_q[IDX_W-1:0];
    end
    if (hit) begin
      pick_q      <= cmp_idx_q;
      pick_size_q <= rdata;
    end
  end

  // Taken flags: a load frees its slot, a successful allocation claims its pick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (load_wr) begin
      taken_q[IDX_W'(slot_q)] <= 1'b0;
    end else if (cmd_i.commit && (op_q == OP_ALLOC) && found_q) begin
      taken_q[pick_q] <= 1'b1;
    end
  end

  // Output register holds one result word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_echo_q <= pid_q;
      if (op_q == OP_LOAD) begin
        out_status_q <= STAT_LOADED;
        out_index_q  <= slot_q;
      end else if (found_q) begin
        out_status_q <= STAT_ALLOC;
        out_index_q  <= SLOT_W'(pick_q);
      end else begin
        out_status_q <= STAT_NOFIT;
        out_index_q  <= '0;
      end
    end
  end

  // Status toward the controller.
  assign status_o.scan_req  = (operation_i == OP_ALLOC) &&
                              ((policy_i == POL_FIRST) || (policy_i == POL_BEST) ||
                               (policy_i == POL_WORST));
  assign status_o.scan_done = (issue_q >= limit);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_index_o  = out_index_q;
  assign out_echo_o   = out_echo_q;

endmodule

// ===== design/fpfa_ctrl.sv =====
module fpfa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fpfa_pkg::fpfa_status_t status_i,
  output fpfa_pkg::fpfa_cmd_t    cmd_o
);
  import fpfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept = in_valid_i && ready_q;

  // Sequencer: take a word, scan the table if it is an allocation, then commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ready_q <= 1'b0;
            state_q <= status_i.scan_req ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          if (status_i.scan_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (status_i.out_free) begin
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          ready_q <= 1'b1;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o   = ready_q;
  assign cmd_o.accept = accept;
  assign cmd_o.step   = (state_q == S_SCAN);
  assign cmd_o.commit = (state_q == S_FINISH) && status_i.out_free;

endmodule

// ===== design/fixed_partition_fit_allocator_unit.sv =====
// Fixed-partition allocator with first, best and worst fit placement. A load word
// writes one partition size and frees that partition; an allocate word scans the
// first partition_count entries (at most 16) and claims the chosen free entry that
// is large enough, ties going to the lowest index. Every word yields one result
// word. Acceptance closes the input until that word's result is committed. A load
// goes straight to commit; an allocate first scans the table, one entry per cycle
// through the single read port of the size memory, and commits once the last entry
// read has been compared. The input reopens after the commit.
// A finished result waits in the output register while the next word is accepted;
// its commit waits only if that register is still full.
module fixed_partition_fit_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fpfa_pkg::CNT_W-1:0] cfg_wdata_i,
  fpfa_item_if.sink                  item_i,
  fpfa_result_if.source              result_o
);
  import fpfa_pkg::*;

  fpfa_cmd_t    cmd;
  fpfa_status_t status;

  fpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fpfa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .operation_i  (item_i.operation),
    .policy_i     (item_i.policy),
    .slot_index_i (item_i.slot_index),
    .size_value_i (item_i.size_value),
    .process_id_i (item_i.process_id),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .out_status_o (result_o.status),
    .out_index_o  (result_o.partition_index),
    .out_echo_o   (result_o.echo_id)
  );

endmodule

// ===== design/fpfa_checker.sv =====
module fpfa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [fpfa_pkg::STAT_W-1:0] out_status_i,
  input logic [fpfa_pkg::SLOT_W-1:0] out_index_i,
  input logic [fpfa_pkg::PID_W-1:0]  out_echo_i
);
  import fpfa_pkg::*;

  // Only one word is in flight: acceptance drops ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while a word is still in work");

  // A result carries one of the three defined status codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_status_i == STAT_LOADED) || (out_status_i == STAT_ALLOC) ||
                     (out_status_i == STAT_NOFIT)))
    else $error("result with an undefined status code");

  // A failed allocation reports index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i == STAT_NOFIT)) |-> (out_index_i == '0))
    else $error("no-fit result with a nonzero index");

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_status_i) && $stable(out_index_i) && $stable(out_echo_i)))
    else $error("stalled result word changed");

endmodule

bind fixed_partition_fit_allocator_unit fpfa_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.status),
  .out_index_i  (result_o.partition_index),
  .out_echo_i   (result_o.echo_id)
);
